// ===== sv/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg: shared constants and functions of the cartesian to spherical converter
// Default sizes, angle constants in Q30 radians, the CORDIC arctangent table and
// the elaboration-time square root from which the inverse CORDIC gain is formed.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int ANGLE_BITS_DEF    = 24;
    localparam int CORDIC_STAGES_DEF = 22;

    localparam int GUARD_BITS = 8;
    localparam int ANG_W      = 35;
    localparam int K_W        = 31;
    localparam int LO_W       = 30;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

    function automatic logic [31:0] f_atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'd843314856;
            1:       v = 32'd497837829;
            2:       v = 32'd263043836;
            3:       v = 32'd133525158;
            4:       v = 32'd67021686;
            5:       v = 32'd33543515;
            6:       v = 32'd16775850;
            7:       v = 32'd8388437;
            8:       v = 32'd4194282;
            9:       v = 32'd2097149;
            10:      v = 32'd1048576;
            11:      v = 32'd524288;
            12:      v = 32'd262144;
            13:      v = 32'd131072;
            14:      v = 32'd65536;
            15:      v = 32'd32768;
            16:      v = 32'd16384;
            17:      v = 32'd8192;
            18:      v = 32'd4096;
            19:      v = 32'd2048;
            20:      v = 32'd1024;
            21:      v = 32'd512;
            22:      v = 32'd256;
            23:      v = 32'd128;
            24:      v = 32'd64;
            25:      v = 32'd32;
            26:      v = 32'd16;
            27:      v = 32'd8;
            28:      v = 32'd4;
            29:      v = 32'd2;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Square root of 2^60 times the CORDIC gain squared, never zero.
    // The inverse gain in Q30 is 2^60 divided by this value, rounded.
    function automatic logic [63:0] f_gain_root(input int stages);
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        p = 64'd1 << 60;
        for (int i = 0; i < stages && i < 32; i++) begin
            p = p + (p >> (2 * i));
        end
        n   = p;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (n >= res + b) begin
                n   = n - res - b;
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return (res == 64'd0) ? 64'd1 : res;
    endfunction

endpackage

// ===== sv/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical: 3-D position to azimuth, elevation and radius
// Accepts one position per clock cycle while the output is not back pressured.
// Each result passes through two fully unrolled CORDIC vectoring pipelines, each
// with a fold stage and two gain correction stages, plus the output register.
// The first pass turns (x, y) into the azimuth and the horizontal length, the
// second turns (length, z) into the elevation and the radius. Azimuth is
// -atan2(y, x), plus a quarter turn without wrap when the ear-centered mode bit
// is set; angles are signed Q3.20 radians and the radius is unsigned Q8.16,
// saturated at full scale. A back pressured output stalls the pipelines without
// losing or repeating a transaction.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
    parameter int COORD_BITS    = c2s_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS    = c2s_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // azimuth, elevation, radius
    output logic [((2*ANGLE_BITS+COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [2:0]                                    paddr,
    input  logic [31:0]                                   pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);
    import c2s_pkg::*;

    localparam int W     = (COORD_BITS + GUARD_BITS + 3 > 32) ?
                           COORD_BITS + GUARD_BITS + 3 : 32;
    localparam int EXT_W = W - COORD_BITS - GUARD_BITS;
    localparam int OUT_W = ((2*ANGLE_BITS+COORD_BITS+7)/8)*8;
    localparam int SH    = 34 - ANGLE_BITS;
    localparam logic [0:0] REG_EAR_MODE = 1'b0;

    localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(1) << (SH - 1);
    localparam logic signed [ANG_W-1:0] A_MAX   = (ANG_W'(1) << (ANGLE_BITS - 1)) - 1;
    localparam logic signed [ANG_W-1:0] A_MIN   = -A_MAX - 1;
    localparam logic [W-1:0]            R_RND   = W'(1) << (GUARD_BITS - 1);

    function automatic logic [ANGLE_BITS-1:0] f_angle_out(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] v;
        v = (a + ANG_RND) >>> SH;
        if (v > A_MAX) begin
            v = A_MAX;
        end else if (v < A_MIN) begin
            v = A_MIN;
        end
        return v[ANGLE_BITS-1:0];
    endfunction

    logic r_mode;
    logic cfg_wr;

    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [W-1:0]          x_w;
    logic signed [W-1:0]          y_w;
    logic signed [W-1:0]          z_w;

    logic                    p1_valid;
    logic                    p1_ready;
    logic signed [W-1:0]     p1_len;
    logic signed [ANG_W-1:0] p1_ang;
    logic [W-1:0]            p1_side;
    logic signed [ANG_W-1:0] az_q30;
    logic [ANGLE_BITS-1:0]   az_out;

    logic                    p2_valid;
    logic                    p2_ready;
    logic signed [W-1:0]     p2_len;
    logic signed [ANG_W-1:0] p2_ang;
    logic [ANGLE_BITS-1:0]   p2_side;

    logic [W-1:0]          rad_sh;
    logic [COORD_BITS-1:0] n_rad;

    logic                  r_out_v;
    logic [ANGLE_BITS-1:0] r_az;
    logic [ANGLE_BITS-1:0] r_el;
    logic [COORD_BITS-1:0] r_rad;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_EAR_MODE) ? {31'b0, r_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (cfg_wr && paddr[2] == REG_EAR_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign pos_x = s_axis_tdata[COORD_BITS-1:0];
    assign pos_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign pos_z = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign x_w   = {{EXT_W{pos_x[COORD_BITS-1]}}, pos_x, {GUARD_BITS{1'b0}}};
    assign y_w   = {{EXT_W{pos_y[COORD_BITS-1]}}, pos_y, {GUARD_BITS{1'b0}}};
    assign z_w   = {{EXT_W{pos_z[COORD_BITS-1]}}, pos_z, {GUARD_BITS{1'b0}}};

    c2s_vec_pass #(
        .W      (W),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (W)
    ) u_pass_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (x_w),
        .i_y     (y_w),
        .i_side  (z_w),
        .o_valid (p1_valid),
        .i_ready (p1_ready),
        .o_len   (p1_len),
        .o_ang   (p1_ang),
        .o_side  (p1_side)
    );

    assign az_q30 = -p1_ang + (r_mode ? HALF_PI_Q30 : '0);
    assign az_out = f_angle_out(az_q30);

    c2s_vec_pass #(
        .W      (W),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (ANGLE_BITS)
    ) u_pass_rz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p1_valid),
        .o_ready (p1_ready),
        .i_x     (p1_len),
        .i_y     (signed'(p1_side)),
        .i_side  (az_out),
        .o_valid (p2_valid),
        .i_ready (p2_ready),
        .o_len   (p2_len),
        .o_ang   (p2_ang),
        .o_side  (p2_side)
    );

    assign p2_ready = ~r_out_v | m_axis_tready;

    assign rad_sh = (p2_len + R_RND) >> GUARD_BITS;
    assign n_rad  = (|rad_sh[W-1:COORD_BITS]) ? '1 : rad_sh[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (p2_ready) begin
            r_out_v <= p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_ready && p2_valid) begin
            r_az  <= p2_side;
            r_el  <= f_angle_out(p2_ang);
            r_rad <= n_rad;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'({r_rad, r_el, r_az});

endmodule

// ===== sv/c2s_vec_pass.sv =====
// ----------------------------------------------------------------------------
// c2s_vec_pass: pipelined CORDIC vectoring pass with gain correction
// One register stage for the half-plane fold, one per CORDIC iteration, one for
// the gain partial products and one for their sum. A side word rides along.
// ----------------------------------------------------------------------------
module c2s_vec_pass #(
    parameter int W      = 35,
    parameter int STAGES = 22,
    parameter int SIDE_W = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [W-1:0]              i_x,
    input  logic signed [W-1:0]              i_y,
    input  logic [SIDE_W-1:0]                i_side,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [W-1:0]              o_len,
    output logic signed [c2s_pkg::ANG_W-1:0] o_ang,
    output logic [SIDE_W-1:0]                o_side
);
    import c2s_pkg::*;

    localparam int LAST = STAGES + 2;
    localparam int HI_W = W - LO_W;
    localparam int PL_W = LO_W + K_W;
    localparam logic [63:0]     GAIN_S = f_gain_root(STAGES);
    localparam logic [K_W-1:0]  GAIN_K = K_W'(((64'd1 << 60) + (GAIN_S >> 1)) / GAIN_S);
    localparam logic [PL_W-1:0] RND    = PL_W'(1) << (LO_W - 1);

    logic ce;

    logic              r_v    [0:LAST];
    logic [SIDE_W-1:0] r_side [0:LAST];

    logic signed [W-1:0]     r_x   [0:STAGES];
    logic signed [W-1:0]     r_y   [0:STAGES];
    logic signed [ANG_W-1:0] r_a   [0:STAGES];
    logic                    r_byp [0:STAGES];

    logic signed [W-1:0]     n_x0;
    logic signed [W-1:0]     n_y0;
    logic signed [ANG_W-1:0] n_a0;
    logic                    n_byp0;

    logic signed [W-1:0]     xc;
    logic [HI_W-1:0]         x_hi;
    logic [LO_W-1:0]         x_lo;
    logic [W:0]              r_pa_hi;
    logic [PL_W-1:0]         r_pa_lo;
    logic signed [W-1:0]     r_xa;
    logic signed [ANG_W-1:0] r_aa;
    logic                    r_bypa;

    logic [W:0]              sum;
    logic signed [W-1:0]     n_len;
    logic signed [W-1:0]     r_len;
    logic signed [ANG_W-1:0] r_ab;

    assign ce      = ~r_v[LAST] | i_ready;
    assign o_ready = ce;

    // Left half plane is folded; a zero y freezes the item through all iterations.
    always_comb begin
        n_byp0 = (i_y == '0);
        if (i_x[W-1]) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_a0 = i_y[W-1] ? -PI_Q30 : PI_Q30;
        end else begin
            n_x0 = i_x;
            n_y0 = i_y;
            n_a0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (ce) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= i_side;
            for (int k = 1; k <= LAST; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_x[0]   <= n_x0;
            r_y[0]   <= n_y0;
            r_a[0]   <= n_a0;
            r_byp[0] <= n_byp0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [W-1:0]     xs;
        logic signed [W-1:0]     ys;
        logic signed [ANG_W-1:0] at;
        logic signed [W-1:0]     n_x;
        logic signed [W-1:0]     n_y;
        logic signed [ANG_W-1:0] n_a;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign at = ANG_W'(f_atan_q30(i));

        always_comb begin
            if (r_byp[i]) begin
                n_x = r_x[i];
                n_y = r_y[i];
                n_a = r_a[i];
            end else if (!r_y[i][W-1]) begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_a = r_a[i] + at;
            end else begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_a = r_a[i] - at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_a[i+1]   <= n_a;
                r_byp[i+1] <= r_byp[i];
            end
        end
    end

    // Gain correction: round(x * K / 2^30), split into high and low partial products.
    assign xc   = r_x[STAGES][W-1] ? '0 : r_x[STAGES];
    assign x_hi = xc[W-1:LO_W];
    assign x_lo = xc[LO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pa_hi <= (W+1)'(x_hi) * (W+1)'(GAIN_K);
            r_pa_lo <= PL_W'(x_lo) * PL_W'(GAIN_K);
            r_xa    <= r_x[STAGES];
            r_aa    <= r_a[STAGES];
            r_bypa  <= r_byp[STAGES];
        end
    end

    assign sum   = r_pa_hi + (W+1)'((r_pa_lo + RND) >> LO_W);
    assign n_len = r_bypa ? r_xa : signed'(sum[W-1:0]);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_len <= n_len;
            r_ab  <= r_aa;
        end
    end

    assign o_valid = r_v[LAST];
    assign o_len   = r_len;
    assign o_ang   = r_ab;
    assign o_side  = r_side[LAST];

endmodule
